### sv/fsds_pkg.sv
// ----------------------------------------------------------------------------
// fsds_pkg
// shared widths and constants for the signed difference sum block
// ----------------------------------------------------------------------------
package fsds_pkg;

  // key range of the trees: valid keys are 1 .. KEYS-1
  localparam int unsigned KEYS    = 65536;
  localparam int unsigned ADDR_W  = $clog2(KEYS);

  // item and result field widths
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned VAL_W   = 32;
  localparam int unsigned SCORE_W = 64;

  // tree entry: count in the upper part, value sum in the lower part
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned ENTRY_W = CNT_W + SUM_W;

endpackage

### sv/fenwick_signed_difference_sum.sv
// ----------------------------------------------------------------------------
// fenwick_signed_difference_sum
// signed difference sum over two binary indexed trees held in one ram
// ----------------------------------------------------------------------------
// each item (key, value) is added to a count tree and a value sum tree, then
// the count and sum of stored items with a smaller key are read back and the
// block returns count_hi*v - sum_hi + sum_lo - count_lo*v, wrapping at 64
// bits. an item is taken when start is high and busy is low. exactly one
// result per item appears on score_o / key_error_o for one cycle with done_o
// high; the receiver cannot hold it off. a key of zero or not below KEYS is
// rejected: done_o follows on the next cycle with key_error_o high and a
// score of zero, and nothing is stored. a valid item is taken, which issues
// the first read, then the block walks the update path and then the prefix
// path, one tree entry per step; the two walks always add up to log2(KEYS) =
// 16 steps, since the steps up from a key and the steps down from the key
// below it cover the key width between them. the states S_DIF, S_MUL and
// S_FIN then form the difference, the multiply and the final add. done_o goes
// high as the block returns to idle, and the next item can be taken in that
// same cycle; no item is taken while busy is high. the walks are set by the
// single read port of the tree ram, which they share one entry a cycle.
// after reset busy stays high while every entry of the ram is cleared.
// ----------------------------------------------------------------------------
module fenwick_signed_difference_sum (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [fsds_pkg::KEY_W-1:0]        item_key_i,
  input  logic signed [fsds_pkg::VAL_W-1:0] item_value_i,
  output logic                              done_o,
  output logic signed [fsds_pkg::SCORE_W-1:0] score_o,
  output logic                              key_error_o
);

  localparam int unsigned AW = fsds_pkg::ADDR_W;

  // sequencer codes
  localparam logic [2:0] S_CLR  = 3'd0;  // clearing pass after reset
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;  // update walk, upwards
  localparam logic [2:0] S_PRE  = 3'd3;  // prefix walk, downwards
  localparam logic [2:0] S_DIF  = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  localparam logic [AW-1:0] LAST_ADDR = AW'(fsds_pkg::KEYS - 1);
  localparam logic [AW:0]   KEYS_EXT  = (AW + 1)'(fsds_pkg::KEYS);

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] clr_q;
  logic [AW-1:0] pos_q, pos_d;
  logic [AW-1:0] key_q;

  logic signed [fsds_pkg::VAL_W-1:0] val_q;
  logic [fsds_pkg::CNT_W-1:0]        items_q;
  logic [fsds_pkg::SUM_W-1:0]        total_q;
  logic [fsds_pkg::CNT_W-1:0]        lo_cnt_q;
  logic [fsds_pkg::SUM_W-1:0]        lo_sum_q;
  logic signed [fsds_pkg::CNT_W:0]   diff_q;   // hi count minus lo count
  logic [fsds_pkg::SUM_W-1:0]        sdiff_q;  // lo sum minus hi sum
  logic [fsds_pkg::SCORE_W-1:0]      prod_q;
  logic [fsds_pkg::SCORE_W-1:0]      score_q;
  logic                              err_q;
  logic                              done_q;

  // ram port
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [fsds_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [fsds_pkg::ENTRY_W-1:0]  ram_rdata;

  logic [fsds_pkg::CNT_W-1:0]    rd_cnt;
  logic [fsds_pkg::SUM_W-1:0]    rd_sum;
  logic [fsds_pkg::SUM_W-1:0]    val_ext;
  logic [fsds_pkg::SUM_W-1:0]    in_val_ext;

  logic          key_ok;
  logic          accept;
  logic [AW-1:0] low_bit;
  logic [AW:0]   nxt_up;
  logic [AW-1:0] nxt_dn;
  logic [AW-1:0] key_m1;
  logic [fsds_pkg::CNT_W-1:0]      hi_cnt;
  logic signed [fsds_pkg::SCORE_W:0] prod_w;

  assign rd_cnt     = ram_rdata[fsds_pkg::ENTRY_W-1 -: fsds_pkg::CNT_W];
  assign rd_sum     = ram_rdata[fsds_pkg::SUM_W-1:0];
  assign val_ext    = fsds_pkg::SUM_W'(val_q);
  assign in_val_ext = fsds_pkg::SUM_W'(item_value_i);

  // key zero and keys beyond the tree are rejected
  assign key_ok = (item_key_i != '0) && (32'(item_key_i) < fsds_pkg::KEYS);
  assign accept = start && (state_q == S_IDLE);

  // walk steps: up adds the lowest set bit, down clears it
  assign low_bit = pos_q & (~pos_q + 1'b1);
  assign nxt_up  = {1'b0, pos_q} + {1'b0, low_bit};
  assign nxt_dn  = pos_q & (pos_q - 1'b1);
  assign key_m1  = key_q - 1'b1;

  assign hi_cnt  = items_q - lo_cnt_q;
  assign prod_w  = diff_q * val_q;

  // sequencer and ram control
  // update positions are all >= key and prefix positions all < key, so the
  // last update write never meets the first prefix read
  always_comb begin
    state_d   = state_q;
    pos_d     = pos_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = {rd_cnt + 1'b1, rd_sum + val_ext};
    ram_raddr = pos_q;
    case (state_q)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == LAST_ADDR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start && key_ok) begin
          ram_raddr = AW'(item_key_i);
          pos_d     = AW'(item_key_i);
          state_d   = S_UPD;
        end
      end
      S_UPD: begin
        // read data belongs to pos_q; next read is issued alongside the write
        ram_we = 1'b1;
        if (nxt_up < KEYS_EXT) begin
          ram_raddr = nxt_up[AW-1:0];
          pos_d     = nxt_up[AW-1:0];
        end else if (key_m1 == '0) begin
          state_d = S_DIF;
        end else begin
          ram_raddr = key_m1;
          pos_d     = key_m1;
          state_d   = S_PRE;
        end
      end
      S_PRE: begin
        if (nxt_dn != '0) begin
          ram_raddr = nxt_dn;
          pos_d     = nxt_dn;
        end else begin
          state_d = S_DIF;
        end
      end
      S_DIF:   state_d = S_MUL;
      S_MUL:   state_d = S_FIN;
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= '0;
      items_q <= '0;
      total_q <= '0;
      done_q  <= 1'b0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= 1'b0;
      if (state_q == S_CLR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (accept) begin
        if (key_ok) begin
          // running totals stand in for the full range query
          items_q <= items_q + 1'b1;
          total_q <= total_q + in_val_ext;
        end else begin
          done_q <= 1'b1;
          err_q  <= 1'b1;
        end
      end
      if (state_q == S_FIN) begin
        done_q <= 1'b1;
        err_q  <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          key_q    <= AW'(item_key_i);
          val_q    <= item_value_i;
          lo_cnt_q <= '0;
          lo_sum_q <= '0;
          score_q  <= '0;
        end
      end
      S_PRE: begin
        lo_cnt_q <= lo_cnt_q + rd_cnt;
        lo_sum_q <= lo_sum_q + rd_sum;
      end
      S_DIF: begin
        diff_q  <= $signed({1'b0, hi_cnt}) - $signed({1'b0, lo_cnt_q});
        // lo_sum - (total - lo_sum)
        sdiff_q <= {lo_sum_q[fsds_pkg::SUM_W-2:0], 1'b0} - total_q;
      end
      S_MUL: begin
        prod_q <= prod_w[fsds_pkg::SCORE_W-1:0];
      end
      S_FIN: begin
        score_q <= prod_q + sdiff_q;
      end
      default: begin
      end
    endcase
  end

  fsds_ram #(
    .WIDTH (fsds_pkg::ENTRY_W),
    .DEPTH (fsds_pkg::KEYS)
  ) u_tree_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign score_o     = $signed(score_q);
  assign key_error_o = err_q;

endmodule

### sv/fsds_ram.sv
// ----------------------------------------------------------------------------
// fsds_ram
// generic simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fsds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/fsds_checker.sv
// ----------------------------------------------------------------------------
// fsds_checker
// port level checks for the signed difference sum block
// ----------------------------------------------------------------------------
module fsds_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start,
  input logic                                busy,
  input logic [fsds_pkg::KEY_W-1:0]          item_key_i,
  input logic signed [fsds_pkg::VAL_W-1:0]   item_value_i,
  input logic                                done_o,
  input logic signed [fsds_pkg::SCORE_W-1:0] score_o,
  input logic                                key_error_o
);

  logic item_taken;
  logic key_bad;

  assign item_taken = start && !busy;
  assign key_bad    = (item_key_i == '0) || (32'(item_key_i) >= fsds_pkg::KEYS);

  // a result is only shown once the block is free again
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // a rejected item scores zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && key_error_o) |-> (score_o == '0))
    else $error("rejected item with non-zero score");

  // a bad key is answered on the next cycle with the error flag
  a_bad_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_taken && key_bad) |=> (done_o && key_error_o && !busy))
    else $error("bad key not flagged at once");

  // a good key starts the tree walks
  a_good_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_taken && !key_bad) |=> (busy && !done_o))
    else $error("good key did not start the walks");

endmodule

bind fenwick_signed_difference_sum fsds_checker u_fsds_checker (.*);
